// ----- hdl/msp_pkg.sv -----
`timescale 1ns / 1ps
package msp_pkg;

  localparam int MAX_CH    = 8;
  localparam int CH_W      = 3;
  localparam int KIND_W    = 3;
  localparam int FREQ_W    = 8;
  localparam int DUTY_W    = 10;
  localparam int ELAPSED_W = 16;
  localparam int PERIOD_W  = 20;
  localparam int PROG_W    = 32;
  localparam int PROD_W    = 40;
  localparam int CNT_W     = 6;
  localparam int QDEPTH    = 2;

  localparam int SCALE_IN_W = 30;
  localparam int RECIP_W    = 31;
  localparam int RECIP_SH   = 40;

  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

  localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DUTY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREQ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LEVEL = 3'd4;

  localparam logic [PERIOD_W-1:0] US_PER_SEC = 20'd1000000;
  localparam logic [PERIOD_W-1:0] DUTY_FULL  = 20'd1000;
  localparam logic [DUTY_W-1:0]   DUTY_MAX   = 10'd1000;

  // ceil(2^40 / 1000): exact floor(x / 1000) for x below 2^30
  localparam logic [RECIP_W-1:0] DUTY_RECIP = 31'd1099511628;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START,
    OP_DUTY,
    OP_FREQ,
    OP_LEVEL,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [CH_W-1:0]      ch;
    logic [FREQ_W-1:0]    freq;
    logic [DUTY_W-1:0]    duty;
    logic                 level;
    logic [ELAPSED_W-1:0] elapsed;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_CMP,
    ST_DIV1,
    ST_MUL,
    ST_SCALE,
    ST_DIV2GO,
    ST_DIV2,
    ST_FIN
  } st_t;

  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- hdl/msp_ifs.sv -----
`timescale 1ns / 1ps
interface msp_in_if;
  logic                           valid;
  logic                           ready;
  logic [msp_pkg::KIND_W-1:0]     kind;
  logic [msp_pkg::CH_W-1:0]       channel;
  logic [msp_pkg::FREQ_W-1:0]     freq_hz;
  logic [msp_pkg::DUTY_W-1:0]     duty_tenths;
  logic                           level;
  logic [msp_pkg::ELAPSED_W-1:0]  elapsed_us;

  modport source (output valid, kind, channel, freq_hz, duty_tenths, level, elapsed_us,
                  input ready);
  modport sink (input valid, kind, channel, freq_hz, duty_tenths, level, elapsed_us,
                output ready);
endinterface

interface msp_out_if;
  logic                        valid;
  logic                        ready;
  logic [msp_pkg::MAX_CH-1:0]  output_bits;
  logic                        changed;
  logic                        accepted;

  modport source (output valid, output_bits, changed, accepted, input ready);
  modport sink (input valid, output_bits, changed, accepted, output ready);
endinterface

// ----- hdl/multi_channel_soft_pwm.sv -----
`timescale 1ns / 1ps
// Software PWM over eight output bits: each word on in_ch is a tick or a channel command and
// gives exactly one word on out_ch with the output byte, a changed flag and an accepted flag.
// Words are queued two deep ahead of a sequencer that handles one word at a time. A tick
// walks every channel with an add step, plus a compare step per PWM channel. Start pwm
// divides, multiplies and scales; update freq divides, multiplies and divides again (only
// the first divide while the channel has no period yet); update duty multiplies and scales;
// static level and ignored words go straight to the output. The shared 40-step divider
// gives one quotient bit a cycle, while the duty scaling is a single reciprocal multiply.
module multi_channel_soft_pwm #(
  parameter int CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  msp_in_if.sink    in_ch,
  msp_out_if.source out_ch
);

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  msp_pkg::item_t    push_data;
  msp_pkg::item_t    head;
  msp_pkg::div_req_t div_req;
  msp_pkg::div_rsp_t div_rsp;

  msp_front #(.CHANNELS(CHANNELS)) u_front (
    .in_ch     (in_ch),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  msp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  msp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  msp_back #(.CHANNELS(CHANNELS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule

// ----- hdl/msp_fifo.sv -----
`timescale 1ns / 1ps
module msp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  msp_pkg::item_t push_data,
  output logic           full,
  input  logic           pop,
  output msp_pkg::item_t pop_data,
  output logic           empty
);

  localparam int PTR_W = $clog2(msp_pkg::QDEPTH);

  msp_pkg::item_t   mem_r [msp_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == (PTR_W+1)'(msp_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ----- hdl/msp_front.sv -----
`timescale 1ns / 1ps
module msp_front #(
  parameter int CHANNELS = 8
) (
  msp_in_if.sink         in_ch,
  input  logic           full,
  output logic           push,
  output msp_pkg::item_t push_data
);

  logic ch_ok;
  logic freq_ok;
  logic duty_ok;

  assign ch_ok   = {1'b0, in_ch.channel} < (msp_pkg::CH_W+1)'(CHANNELS);
  assign freq_ok = (in_ch.freq_hz != '0);
  assign duty_ok = (in_ch.duty_tenths <= msp_pkg::DUTY_MAX);

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  always_comb begin
    push_data.ch      = in_ch.channel;
    push_data.freq    = in_ch.freq_hz;
    push_data.duty    = in_ch.duty_tenths;
    push_data.level   = in_ch.level;
    push_data.elapsed = in_ch.elapsed_us;
    priority if (in_ch.kind == msp_pkg::KIND_TICK) begin
      push_data.op = msp_pkg::OP_TICK;
    end else if (!ch_ok) begin
      push_data.op = msp_pkg::OP_DROP;
    end else begin
      unique case (in_ch.kind)
        msp_pkg::KIND_START: push_data.op = (freq_ok && duty_ok) ? msp_pkg::OP_START
                                                                 : msp_pkg::OP_DROP;
        msp_pkg::KIND_DUTY:  push_data.op = duty_ok ? msp_pkg::OP_DUTY : msp_pkg::OP_DROP;
        msp_pkg::KIND_FREQ:  push_data.op = freq_ok ? msp_pkg::OP_FREQ : msp_pkg::OP_DROP;
        msp_pkg::KIND_LEVEL: push_data.op = msp_pkg::OP_LEVEL;
        default:             push_data.op = msp_pkg::OP_DROP;
      endcase
    end
  end

endmodule

// ----- hdl/msp_div.sv -----
`timescale 1ns / 1ps
module msp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  msp_pkg::div_req_t req,
  output msp_pkg::div_rsp_t rsp
);

  logic [msp_pkg::CNT_W-1:0]    cnt_r;
  logic                         done_r;
  logic [msp_pkg::PROD_W-1:0]   dvd_r;
  logic [msp_pkg::PERIOD_W-1:0] dvr_r;
  logic [msp_pkg::PERIOD_W-1:0] rem_r;
  logic [msp_pkg::PERIOD_W:0]   rem_sh;
  logic [msp_pkg::PERIOD_W:0]   rem_dif;
  logic                         ge;

  // restoring divide, one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[msp_pkg::PROD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvr_r};
  assign rem_dif = rem_sh - {1'b0, dvr_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && (cnt_r == msp_pkg::CNT_W'(1));
      if (req.start) cnt_r <= msp_pkg::DIV_STEPS;
      else if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvr_r <= req.divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? rem_dif[msp_pkg::PERIOD_W-1:0] : rem_sh[msp_pkg::PERIOD_W-1:0];
      dvd_r <= {dvd_r[msp_pkg::PROD_W-2:0], ge};
    end
  end

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(cnt_r) == msp_pkg::CNT_W'(1))
    else $error("divider done without finishing its steps");

endmodule

// ----- hdl/msp_back.sv -----
`timescale 1ns / 1ps
module msp_back #(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  msp_pkg::item_t    head,
  output logic              pop,
  output msp_pkg::div_req_t div_req,
  input  msp_pkg::div_rsp_t div_rsp,
  msp_out_if.source         out_ch
);

  localparam logic [msp_pkg::CH_W-1:0]   LAST_CH = msp_pkg::CH_W'(CHANNELS - 1);
  localparam logic [msp_pkg::MAX_CH-1:0] CH_MASK = msp_pkg::MAX_CH'((1 << CHANNELS) - 1);
  localparam int SCALED_W = msp_pkg::SCALE_IN_W + msp_pkg::RECIP_W;

  msp_pkg::st_t state_r;
  msp_pkg::st_t state_nxt;

  logic [msp_pkg::PERIOD_W-1:0] period_r   [msp_pkg::MAX_CH];
  logic [msp_pkg::PERIOD_W-1:0] trigger_r  [msp_pkg::MAX_CH];
  logic [msp_pkg::PROG_W-1:0]   progress_r [msp_pkg::MAX_CH];
  logic [msp_pkg::MAX_CH-1:0]   pwm_on_r;
  logic [msp_pkg::MAX_CH-1:0]   cache_r;

  msp_pkg::item_t               cur_r;
  logic [msp_pkg::CH_W-1:0]     idx_r;
  logic [msp_pkg::PROG_W-1:0]   sum_r;
  logic [msp_pkg::PERIOD_W-1:0] fresh_r;
  logic [msp_pkg::PROD_W-1:0]   prod_r;
  logic [msp_pkg::MAX_CH-1:0]   before_r;
  logic                         acc_r;
  logic                         chg_r;

  logic                         out_valid_r;
  logic [msp_pkg::MAX_CH-1:0]   out_bits_r;
  logic                         out_chg_r;
  logic                         out_acc_r;
  logic                         out_load;

  logic [msp_pkg::PERIOD_W-1:0] per;
  logic [msp_pkg::PERIOD_W-1:0] trg;
  logic [msp_pkg::PROG_W-1:0]   prg;
  logic                         on;
  logic                         last;
  logic [msp_pkg::PERIOD_W-1:0] mul_a;
  logic [msp_pkg::PERIOD_W-1:0] mul_b;
  logic [SCALED_W-1:0]          scaled;
  logic                         trig_wr;
  logic [msp_pkg::PERIOD_W-1:0] trig_val;

  assign per   = period_r[idx_r];
  assign trg   = trigger_r[idx_r];
  assign prg   = progress_r[idx_r];
  assign on    = pwm_on_r[idx_r];
  assign last  = (idx_r == LAST_CH);
  assign mul_a = (cur_r.op == msp_pkg::OP_DUTY) ? per : fresh_r;
  assign mul_b = (cur_r.op == msp_pkg::OP_FREQ) ? trg : msp_pkg::PERIOD_W'(cur_r.duty);

  // period * duty stays below 2^30, so the reciprocal gives the exact floor of / 1000
  assign scaled   = SCALED_W'(prod_r[msp_pkg::SCALE_IN_W-1:0]) *
                    SCALED_W'(msp_pkg::DUTY_RECIP);
  assign trig_wr  = (state_r == msp_pkg::ST_SCALE) ||
                    (state_r == msp_pkg::ST_DIV2 && div_rsp.done);
  assign trig_val = (state_r == msp_pkg::ST_SCALE) ?
                    scaled[msp_pkg::RECIP_SH +: msp_pkg::PERIOD_W] :
                    div_rsp.quotient[msp_pkg::PERIOD_W-1:0];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.output_bits = out_bits_r;
  assign out_ch.changed     = out_chg_r;
  assign out_ch.accepted    = out_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    pop              = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = prod_r;
    div_req.divisor  = per;
    unique case (state_r)
      msp_pkg::ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.op)
            msp_pkg::OP_TICK: state_nxt = msp_pkg::ST_ADD;
            msp_pkg::OP_START, msp_pkg::OP_FREQ: begin
              div_req.start    = 1'b1;
              div_req.dividend = msp_pkg::PROD_W'(msp_pkg::US_PER_SEC);
              div_req.divisor  = msp_pkg::PERIOD_W'(head.freq);
              state_nxt        = msp_pkg::ST_DIV1;
            end
            msp_pkg::OP_DUTY:                     state_nxt = msp_pkg::ST_MUL;
            msp_pkg::OP_LEVEL, msp_pkg::OP_DROP:  state_nxt = msp_pkg::ST_FIN;
            default:                              state_nxt = msp_pkg::ST_FIN;
          endcase
        end
      end
      msp_pkg::ST_ADD: begin
        if (on) state_nxt = msp_pkg::ST_CMP;
        else if (last) state_nxt = msp_pkg::ST_FIN;
      end
      msp_pkg::ST_CMP: state_nxt = last ? msp_pkg::ST_FIN : msp_pkg::ST_ADD;
      msp_pkg::ST_DIV1: begin
        if (div_rsp.done) begin
          // old period of zero: trigger goes to zero, no rescale
          state_nxt = (cur_r.op == msp_pkg::OP_FREQ && per == '0) ? msp_pkg::ST_FIN
                                                                  : msp_pkg::ST_MUL;
        end
      end
      msp_pkg::ST_MUL: begin
        state_nxt = (cur_r.op == msp_pkg::OP_FREQ) ? msp_pkg::ST_DIV2GO : msp_pkg::ST_SCALE;
      end
      msp_pkg::ST_SCALE: state_nxt = msp_pkg::ST_FIN;
      msp_pkg::ST_DIV2GO: begin
        div_req.start = 1'b1;
        state_nxt     = msp_pkg::ST_DIV2;
      end
      msp_pkg::ST_DIV2: if (div_rsp.done) state_nxt = msp_pkg::ST_FIN;
      msp_pkg::ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = msp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cache_r     <= '0;
      pwm_on_r    <= '0;
      for (int i = 0; i < msp_pkg::MAX_CH; i++) begin
        period_r[i]   <= '0;
        trigger_r[i]  <= '0;
        progress_r[i] <= '0;
      end
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      if (pop && head.op == msp_pkg::OP_LEVEL) begin
        pwm_on_r[head.ch] <= 1'b0;
        cache_r[head.ch]  <= head.level;
      end

      if (state_r == msp_pkg::ST_CMP) begin
        cache_r[idx_r]    <= (sum_r >= msp_pkg::PROG_W'(trg));
        progress_r[idx_r] <= (sum_r > msp_pkg::PROG_W'(per)) ? sum_r - msp_pkg::PROG_W'(per)
                                                              : sum_r;
      end

      if (state_r == msp_pkg::ST_DIV1 && div_rsp.done &&
          cur_r.op == msp_pkg::OP_FREQ && per == '0) begin
        trigger_r[idx_r] <= '0;
        period_r[idx_r]  <= div_rsp.quotient[msp_pkg::PERIOD_W-1:0];
      end

      if (trig_wr) begin
        trigger_r[idx_r] <= trig_val;
        if (cur_r.op != msp_pkg::OP_DUTY) period_r[idx_r] <= fresh_r;
        if (cur_r.op == msp_pkg::OP_START) begin
          progress_r[idx_r] <= '0;
          pwm_on_r[idx_r]   <= 1'b1;
          cache_r[idx_r]    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r    <= head;
      idx_r    <= (head.op == msp_pkg::OP_TICK) ? '0 : head.ch;
      before_r <= cache_r;
      acc_r    <= (head.op != msp_pkg::OP_DROP);
      chg_r    <= (head.op == msp_pkg::OP_START) || (head.op == msp_pkg::OP_LEVEL);
    end
    if (state_r == msp_pkg::ST_ADD) begin
      sum_r <= prg + msp_pkg::PROG_W'(cur_r.elapsed);
      if (!on && !last) idx_r <= idx_r + 1'b1;
    end
    if (state_r == msp_pkg::ST_CMP && !last) idx_r <= idx_r + 1'b1;
    if (state_r == msp_pkg::ST_DIV1 && div_rsp.done) begin
      fresh_r <= div_rsp.quotient[msp_pkg::PERIOD_W-1:0];
    end
    if (state_r == msp_pkg::ST_MUL) begin
      prod_r <= msp_pkg::PROD_W'(mul_a) * msp_pkg::PROD_W'(mul_b);
    end
    if (out_load) begin
      out_bits_r <= cache_r;
      out_chg_r  <= (cur_r.op == msp_pkg::OP_TICK) ? (cache_r != before_r) : chg_r;
      out_acc_r  <= acc_r;
    end
  end

  a_walk_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msp_pkg::ST_ADD || state_r == msp_pkg::ST_CMP) |-> cur_r.op == msp_pkg::OP_TICK)
    else $error("channel walk outside a tick");

  a_unused_bits_low: assert property (@(posedge clk) disable iff (!rst_n)
    (cache_r & ~CH_MASK) == '0)
    else $error("output bit set above the channel count");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msp_pkg::ST_FIN && (!out_valid_r || out_ch.ready))
      |=> (state_r == msp_pkg::ST_IDLE && out_valid_r))
    else $error("finished item did not reach the output register");

endmodule
